// ----- hw/rtl/nlof_pkg.sv -----
// shared types, constants and the reciprocal table for the outlier flag unit
`timescale 1ns / 1ps

package nlof_pkg;

    localparam int LEVEL_W = 8;
    localparam int POS_W   = 11;
    localparam int SIZE_W  = 12;
    localparam int THR_W   = 8;

    localparam int DEFAULT_MAX_WIDTH  = 2048;
    localparam int DEFAULT_MAX_HEIGHT = 2048;

    localparam logic [SIZE_W-1:0] WIDTH_RESET     = 12'd640;
    localparam logic [SIZE_W-1:0] HEIGHT_RESET    = 12'd480;
    localparam logic [THR_W-1:0]  THRESHOLD_RESET = 8'd70;

    // register bus
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD    = 2'd2;

    localparam int QUEUE_DEPTH = 4;

    // neighbour sum and nonzero count
    localparam int SUM_W   = 11;
    localparam int CNT_W   = 4;
    localparam int RECIP_W = 15;
    // sum * ceil(2^14 / n) >> 14 is exact for sums below 2^11 and n up to 8
    localparam int RECIP_SHIFT = 14;
    localparam int PROD_W      = SUM_W + RECIP_W;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               first;
        logic               produce;
        logic               frame_end;
        logic [POS_W-1:0]   centre_col;
        logic [POS_W-1:0]   centre_row;
    } item_t;

    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] r;
        case (n)
            4'd1:    r = 15'd16384;
            4'd2:    r = 15'd8192;
            4'd3:    r = 15'd5462;
            4'd4:    r = 15'd4096;
            4'd5:    r = 15'd3277;
            4'd6:    r = 15'd2731;
            4'd7:    r = 15'd2341;
            4'd8:    r = 15'd2048;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- hw/rtl/nlof_channels.sv -----
// pixel and verdict channel interfaces
`timescale 1ns / 1ps

interface nlof_pixel_if;
    import nlof_pkg::*;

    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink (input valid, red, green, blue, output ready);
endinterface

interface nlof_result_if;
    import nlof_pkg::*;

    logic             valid;
    logic             ready;
    logic             flagged;
    logic [POS_W-1:0] centre_col;
    logic [POS_W-1:0] centre_row;
    logic             frame_end;

    modport source (output valid, flagged, centre_col, centre_row, frame_end, input ready);
    modport sink (input valid, flagged, centre_col, centre_row, frame_end, output ready);
endinterface

// ----- hw/rtl/nlof_front.sv -----
// front end: raster position tracking and per-pixel level
`timescale 1ns / 1ps

module nlof_front #(
    parameter int MAX_WIDTH  = nlof_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = nlof_pkg::DEFAULT_MAX_HEIGHT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    nlof_pixel_if.sink                      pixel,
    input  logic [nlof_pkg::SIZE_W-1:0]     frame_width,
    input  logic [nlof_pkg::SIZE_W-1:0]     frame_height,
    input  logic                            queue_full,
    output logic                            push_valid,
    output nlof_pkg::item_t                 push_item,
    output logic [$clog2(MAX_WIDTH)-1:0]    push_addr
);
    import nlof_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic [AW-1:0]      col_reg, col_next;
    logic [RW-1:0]      row_reg, row_next;
    logic [WW-1:0]      width_eff;
    logic [HW-1:0]      height_eff;
    logic [WW-1:0]      col_pos, col_inc;
    logic [HW-1:0]      row_pos, row_inc;
    logic [LEVEL_W-1:0] mx, mn;
    logic [LEVEL_W-1:0] level;

    assign pixel.ready = !queue_full;
    assign push_valid  = pixel.valid && !queue_full;

    always_comb
    begin
        if (frame_width < 12'd3)
            width_eff = WW'(3);
        else if (32'(frame_width) > 32'(MAX_WIDTH))
            width_eff = WW'(MAX_WIDTH);
        else
            width_eff = WW'(frame_width);

        if (frame_height < 12'd3)
            height_eff = HW'(3);
        else if (32'(frame_height) > 32'(MAX_HEIGHT))
            height_eff = HW'(MAX_HEIGHT);
        else
            height_eff = HW'(frame_height);
    end

    // position of this pixel; a count left past a shrunk size wraps as a line end
    always_comb
    begin
        col_pos = WW'(col_reg);
        row_pos = HW'(row_reg);
        if (col_pos >= width_eff)
        begin
            col_pos = '0;
            row_pos = row_pos + 1'b1;
        end
        if (row_pos >= height_eff)
            row_pos = '0;

        col_inc = col_pos + 1'b1;
        row_inc = row_pos + 1'b1;
        if (col_inc >= width_eff)
        begin
            col_next = '0;
            row_next = (row_inc >= height_eff) ? '0 : RW'(row_inc);
        end
        else
        begin
            col_next = AW'(col_inc);
            row_next = RW'(row_pos);
        end
    end

    always_comb
    begin
        mx = pixel.red;
        mn = pixel.red;
        if (pixel.green > mx) mx = pixel.green;
        if (pixel.blue > mx)  mx = pixel.blue;
        if (pixel.green < mn) mn = pixel.green;
        if (pixel.blue < mn)  mn = pixel.blue;
        // wraps to 0 for a saturated max with a zero component
        level = mx + LEVEL_W'(mn == '0 && mx != '0);
    end

    always_comb
    begin
        push_item.level      = level;
        push_item.first      = (col_pos == '0) && (row_pos == '0);
        push_item.produce    = (col_pos >= WW'(2)) && (row_pos >= HW'(2));
        push_item.frame_end  = (col_pos == width_eff - 1'b1) && (row_pos == height_eff - 1'b1);
        push_item.centre_col = POS_W'(col_pos - 1'b1);
        push_item.centre_row = POS_W'(row_pos - 1'b1);
        push_addr            = AW'(col_pos);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (push_valid)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ----- hw/rtl/nlof_queue.sv -----
// short fifo between the front end and the back end
`timescale 1ns / 1ps

module nlof_queue #(
    parameter int ADDR_W = $clog2(nlof_pkg::DEFAULT_MAX_WIDTH)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  nlof_pkg::item_t     push_item,
    input  logic [ADDR_W-1:0]   push_addr,
    input  logic                pop,
    output nlof_pkg::item_t     pop_item,
    output logic [ADDR_W-1:0]   pop_addr,
    output logic                full,
    output logic                empty
);
    import nlof_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    item_t             item_mem [QUEUE_DEPTH];
    logic [ADDR_W-1:0] addr_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]    count_reg;

    assign full     = (count_reg == (PTR_W + 1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = item_mem[rd_ptr_reg];
    assign pop_addr = addr_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            item_mem[wr_ptr_reg] <= push_item;
            addr_mem[wr_ptr_reg] <= push_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ----- hw/rtl/nlof_back.sv -----
// back end: line stores, 3x3 window, neighbour average and outlier decision
`timescale 1ns / 1ps

module nlof_back #(
    parameter int MAX_WIDTH = nlof_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            queue_empty,
    input  nlof_pkg::item_t                 pop_item,
    input  logic [$clog2(MAX_WIDTH)-1:0]    pop_addr,
    output logic                            pop,
    input  logic [nlof_pkg::THR_W-1:0]      threshold,
    nlof_result_if.source                   verdict
);
    import nlof_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SUM   = 2'd1;
    localparam logic [1:0] S_JUDGE = 2'd2;

    logic [1:0]         state_reg, state_next;
    item_t              cur_item_reg;
    logic [AW-1:0]      cur_addr_reg;

    logic [LEVEL_W-1:0] older_mem [MAX_WIDTH];
    logic [LEVEL_W-1:0] newer_mem [MAX_WIDTH];
    logic [LEVEL_W-1:0] older_rd_reg, newer_rd_reg;

    logic [LEVEL_W-1:0] win_reg  [9];
    logic [LEVEL_W-1:0] win_next [9];
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [LEVEL_W-1:0] remembered_reg;

    logic [PROD_W-1:0]  quot_prod;
    logic [LEVEL_W-1:0] avg, centre, diff;
    logic               flag;
    logic               out_free, judge_done, judge_fire;

    logic               res_valid_reg;
    logic               res_flagged_reg;
    logic [POS_W-1:0]   res_col_reg, res_row_reg;
    logic               res_end_reg;

    assign verdict.valid      = res_valid_reg;
    assign verdict.flagged    = res_flagged_reg;
    assign verdict.centre_col = res_col_reg;
    assign verdict.centre_row = res_row_reg;
    assign verdict.frame_end  = res_end_reg;

    assign out_free   = !res_valid_reg || verdict.ready;
    assign judge_done = (state_reg == S_JUDGE) && (!cur_item_reg.produce || out_free);
    assign judge_fire = judge_done && cur_item_reg.produce;
    // next word is fetched while the current one is judged
    assign pop        = !queue_empty && ((state_reg == S_IDLE) || judge_done);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!queue_empty)
                    state_next = S_SUM;
            end
            S_SUM:
                state_next = S_JUDGE;
            S_JUDGE:
            begin
                if (judge_done)
                    state_next = queue_empty ? S_IDLE : S_SUM;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // window shifts left, new column from the two line stores and the incoming level
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_next[r*3]     = win_reg[r*3 + 1];
            win_next[r*3 + 1] = win_reg[r*3 + 2];
        end
        win_next[2] = older_rd_reg;
        win_next[5] = newer_rd_reg;
        win_next[8] = cur_item_reg.level;

        sum_next = '0;
        cnt_next = '0;
        for (int i = 0; i < 9; i++)
        begin
            if (i != 4)
            begin
                sum_next = sum_next + SUM_W'(win_next[i]);
                cnt_next = cnt_next + CNT_W'(win_next[i] != '0);
            end
        end
    end

    always_comb
    begin
        quot_prod = PROD_W'(sum_reg) * PROD_W'(recip(cnt_reg));
        avg       = (cnt_reg != '0) ? quot_prod[RECIP_SHIFT +: LEVEL_W] : remembered_reg;
        centre    = win_reg[4];
        diff      = (centre > avg) ? centre - avg : avg - centre;
        flag      = (diff > threshold) && (centre != '0);
    end

    // line stores, registered read
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            older_rd_reg <= older_mem[pop_addr];
            newer_rd_reg <= newer_mem[pop_addr];
        end
        if (state_reg == S_SUM)
        begin
            older_mem[cur_addr_reg] <= newer_rd_reg;
            newer_mem[cur_addr_reg] <= cur_item_reg.level;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_addr_reg <= pop_addr;
        if (state_reg == S_SUM)
        begin
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
        end
        if (judge_fire)
        begin
            res_flagged_reg <= flag;
            res_col_reg     <= cur_item_reg.centre_col;
            res_row_reg     <= cur_item_reg.centre_row;
            res_end_reg     <= cur_item_reg.frame_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cur_item_reg   <= '0;
            remembered_reg <= '0;
            res_valid_reg  <= 1'b0;
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
                cur_item_reg <= pop_item;
            if (state_reg == S_SUM)
            begin
                for (int i = 0; i < 9; i++)
                    win_reg[i] <= win_next[i];
                if (cur_item_reg.first)
                    remembered_reg <= cur_item_reg.level;
            end
            if (judge_fire && flag)
                remembered_reg <= centre;
            if (judge_fire)
                res_valid_reg <= 1'b1;
            else if (verdict.ready)
                res_valid_reg <= 1'b0;
        end
    end

`ifndef SYNTHESIS
    a_pop_has_word: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !queue_empty)
        else $error("pop from an empty queue");

    a_sum_then_judge: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SUM |=> state_reg == S_JUDGE)
        else $error("sum step not followed by judge step");

    a_remembered_source: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(remembered_reg) |->
            ($past(state_reg == S_SUM && cur_item_reg.first) || $past(judge_fire && flag)))
        else $error("remembered level changed outside frame start or a flagged centre");
`endif

endmodule

// ----- hw/rtl/neighbour_level_outlier_flag_unit.sv -----
// top level: register bank and the front end, queue and back end
`timescale 1ns / 1ps

// Flags pixels whose level stands out from the average of their nonzero neighbours.
// pixel: RGB words in raster order, accepted when valid and ready are both high.
// verdict: one word per interior pixel (flag, centre column and row, frame end);
// border pixels give no word. The APB port sets frame width, frame height and
// the outlier threshold; write them only while no pixel is in flight.
// The front end takes one pixel a cycle, while the queue is not full, into a
// four-word queue. The back end handles each pixel in steps: a read of both
// line stores at the pixel's column, then the window sum; the average and
// decision overlap the next read. The sustained pixel rate is set by the
// back end's line store read-then-sum sequence.
// When verdict.ready is low the word waits in the output register, the back
// end holds in its decision step, the queue fills and pixel.ready drops.
// Reset restores the default registers, zeroes position counters, the window
// and the remembered level; line stores are not cleared and need no sweep.
module neighbour_level_outlier_flag_unit #(
    parameter int MAX_WIDTH  = nlof_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = nlof_pkg::DEFAULT_MAX_HEIGHT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [nlof_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [nlof_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [nlof_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    nlof_pixel_if.sink                          pixel,
    nlof_result_if.source                       verdict
);
    import nlof_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    logic [SIZE_W-1:0]    width_reg, height_reg;
    logic [THR_W-1:0]     threshold_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 reg_write;

    logic                 push_valid, queue_full, queue_empty, pop;
    item_t                push_item, pop_item;
    logic [AW-1:0]        push_addr, pop_addr;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[APB_ADDR_W-1:2];
    assign reg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (reg_write)
        begin
            unique case (reg_idx)
                REG_FRAME_WIDTH:  width_reg     <= pwdata[SIZE_W-1:0];
                REG_FRAME_HEIGHT: height_reg    <= pwdata[SIZE_W-1:0];
                REG_THRESHOLD:    threshold_reg <= pwdata[THR_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(width_reg);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(height_reg);
            REG_THRESHOLD:    prdata = APB_DATA_W'(threshold_reg);
            default:          prdata = '0;
        endcase
    end

    nlof_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel        (pixel),
        .frame_width  (width_reg),
        .frame_height (height_reg),
        .queue_full   (queue_full),
        .push_valid   (push_valid),
        .push_item    (push_item),
        .push_addr    (push_addr)
    );

    nlof_queue #(
        .ADDR_W (AW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid),
        .push_item (push_item),
        .push_addr (push_addr),
        .pop       (pop),
        .pop_item  (pop_item),
        .pop_addr  (pop_addr),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    nlof_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .pop_item    (pop_item),
        .pop_addr    (pop_addr),
        .pop         (pop),
        .threshold   (threshold_reg),
        .verdict     (verdict)
    );

endmodule
